FILE: rtl/srxf_pkg.sv
// shared types and constants for the resync xor frame receiver
package srxf_pkg;
  localparam int BufBytes = 128;
  localparam int IdxW = $clog2(BufBytes);
  localparam int CntW = $clog2(BufBytes + 1);
  localparam logic [CntW-1:0] HeaderBytes = CntW'(4);

  typedef enum logic [1:0] {
    OP_RECV    = 2'd0,
    OP_RESTART = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CHK0,
    ST_CHK2,
    ST_CHK3,
    ST_DECIDE,
    ST_SCAN,
    ST_SCAN_W,
    ST_MOVE_R,
    ST_MOVE_W,
    ST_RD,
    ST_RD_W,
    ST_OUT
  } state_t;

  localparam logic CFG_SYNC   = 1'b0;
  localparam logic CFG_TARGET = 1'b1;
endpackage

FILE: rtl/sync_resync_xor_frame_receiver_core.sv
// top level of the resync xor frame receiver
//
// channel | direction | content
// in_     | slave     | tdata {read_index[16:10], byte_value[9:2], operation[1:0]}
// out_    | master    | tdata {read_byte, fill_count, reply_code, ok, complete, ignored}
// cfg_    | write     | index 0 sync value, index 1 checksum target
//
// one transaction at a time; a received byte passes write, the check states CHK0, CHK2,
// CHK3 and DECIDE, result and idle; restart and unused ops go straight to result, reads via RD and RD_W
// a resync adds a scan read and wait per scanned byte, a read and a write per moved byte and
// a header re-check; resyncs can chain one after another on a nearly full buffer
// reset clears state, fill count, xor and complete flag and loads sync 0 and target 90; the memory needs no clearing
// the output register holds a result until out_tready; no new transaction meanwhile
module sync_resync_xor_frame_receiver_core import srxf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // operation, byte_value, read_index, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // ignored, complete, ok, code, fill_count, read_byte, zeros
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  logic [7:0] mem [BufBytes];
  logic [7:0] rdata;
  logic       we;
  logic [IdxW-1:0] waddr, raddr;
  logic [7:0] wdata;

  // write-first: a header read right after a write to entry 0 sees the new byte
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
  end

  state_t state_r, state_nxt;
  logic [7:0] sync_r, target_r;
  logic [CntW-1:0] held_r, held_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic done_r, done_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] b0_r, b0_nxt, len_r, len_nxt;
  logic [CntW-1:0] drop_r, drop_nxt, mv_r, mv_nxt;
  logic [7:0] byte_r;
  logic [6:0] ridx_r;
  logic [7:0] rd_r, rd_nxt;
  logic ign_r, ign_nxt;
  logic [CntW+1:0] want;
  logic [CntW:0] pos;

  assign want = (CntW+2)'(HeaderBytes) + (CntW+2)'({len_r, 1'b0});
  assign pos = (CntW+1)'(HeaderBytes) + (CntW+1)'(ridx_r);
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata = {5'd0, rd_r, 8'(held_r),
                      (done_r ? code_r : 8'd0), done_r && code_r == 8'd0, done_r, ign_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= 8'd0;
      target_r <= 8'd90;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SYNC) sync_r <= cfg_wdata;
      else target_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r <= '0;
      xor_r <= '0;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r <= held_nxt;
      xor_r <= xor_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt; b0_r <= b0_nxt; len_r <= len_nxt;
    drop_r <= drop_nxt; mv_r <= mv_nxt; rd_r <= rd_nxt; ign_r <= ign_nxt;
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata[9:2];
      ridx_r <= in_tdata[16:10];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) begin
        case (in_tdata[1:0])
          OP_RECV: state_nxt = (done_r || held_r >= CntW'(BufBytes)) ? ST_OUT : ST_WRITE;
          OP_READ: state_nxt = ST_RD;
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_WRITE:  state_nxt = ST_CHK0;
      ST_CHK0:   state_nxt = ST_CHK2;
      ST_CHK2:   state_nxt = ST_CHK3;
      ST_CHK3:   state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (b0_r != sync_r) state_nxt = ST_SCAN;
        else if (held_r >= HeaderBytes) begin
          if (want > (CntW+2)'(BufBytes)) state_nxt = ST_SCAN;
          else if ((CntW+2)'(held_r) >= want)
            state_nxt = (xor_r != target_r) ? ST_SCAN : ST_OUT;
          else state_nxt = ST_OUT;
        end else state_nxt = ST_OUT;
      end
      ST_SCAN:   state_nxt = ST_SCAN_W;
      ST_SCAN_W: begin
        if (drop_r < held_r && rdata != sync_r) state_nxt = ST_SCAN;
        else if (drop_r >= held_r) state_nxt = ST_OUT;
        else state_nxt = ST_MOVE_R;
      end
      ST_MOVE_R: state_nxt = ST_MOVE_W;
      ST_MOVE_W: state_nxt = (mv_r + 1'b1 + drop_r >= held_r) ? ST_CHK0 : ST_MOVE_R;
      ST_RD:     state_nxt = ST_RD_W;
      ST_RD_W:   state_nxt = ST_OUT;
      ST_OUT:    if (out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    held_nxt = held_r; xor_nxt = xor_r; done_nxt = done_r; code_nxt = code_r;
    b0_nxt = b0_r; len_nxt = len_r; drop_nxt = drop_r; mv_nxt = mv_r;
    rd_nxt = rd_r; ign_nxt = ign_r;
    we = 1'b0; waddr = held_r[IdxW-1:0]; wdata = byte_r; raddr = '0;
    case (state_r)
      ST_IDLE: if (in_tvalid) begin
        ign_nxt = 1'b0; rd_nxt = 8'd0;
        case (in_tdata[1:0])
          OP_RECV: ign_nxt = done_r;
          OP_RESTART: begin held_nxt = '0; xor_nxt = '0; done_nxt = 1'b0; end
          default: ;
        endcase
      end
      ST_WRITE: begin
        we = 1'b1; held_nxt = held_r + 1'b1; xor_nxt = xor_r ^ byte_r;
        raddr = IdxW'(0);
      end
      ST_CHK0: begin b0_nxt = rdata; raddr = IdxW'(2); end
      ST_CHK2: begin len_nxt = rdata; raddr = IdxW'(3); end
      ST_CHK3: code_nxt = rdata;
      ST_DECIDE: begin
        drop_nxt = CntW'(1); mv_nxt = '0;
        if (b0_r == sync_r && held_r >= HeaderBytes && want <= (CntW+2)'(BufBytes)
            && (CntW+2)'(held_r) >= want && xor_r == target_r)
          done_nxt = 1'b1;
        // drop restarts the xor, rebuilt while moving
        xor_nxt = 8'd0;
        if (!(b0_r != sync_r || (held_r >= HeaderBytes && (want > (CntW+2)'(BufBytes) ||
            ((CntW+2)'(held_r) >= want && xor_r != target_r)))))
          xor_nxt = xor_r;
      end
      ST_SCAN: raddr = drop_r[IdxW-1:0];
      ST_SCAN_W: begin
        if (drop_r < held_r && rdata != sync_r) drop_nxt = drop_r + 1'b1;
        else if (drop_r >= held_r) held_nxt = '0;
      end
      ST_MOVE_R: raddr = IdxW'(mv_r + drop_r);
      ST_MOVE_W: begin
        we = 1'b1; waddr = mv_r[IdxW-1:0]; wdata = rdata;
        xor_nxt = xor_r ^ rdata; mv_nxt = mv_r + 1'b1;
        if (mv_r + 1'b1 + drop_r >= held_r) held_nxt = held_r - drop_r;
        raddr = IdxW'(0);
      end
      ST_RD: raddr = pos[IdxW-1:0];
      ST_RD_W:
        if (done_r && code_r == 8'd0 && pos < (CntW+1)'(held_r)
            && pos < (CntW+1)'(BufBytes))
          rd_nxt = rdata;
      default: ;
    endcase
  end
endmodule

FILE: rtl/srxf_checker.sv
// port-level checks for the resync xor frame receiver
module srxf_checker import srxf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");
  a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1] && out_tdata[10:3] == 8'd0)
    else $error("ok without complete zero code");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[18:11] <= 8'(BufBytes)) else $error("fill overflow");
endmodule

bind sync_resync_xor_frame_receiver_core srxf_checker u_chk (.*);

FILE: tb/tb_sync_resync_xor_frame_receiver_core.sv
// testbench for the resync xor frame receiver: directed and random byte streams
`timescale 1ns / 1ps
module tb_sync_resync_xor_frame_receiver_core;
  import srxf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // operation[1:0], byte_value[9:2], read_index[16:10], zeros
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // ignored, complete, ok, code[10:3], fill[18:11], read[26:19]
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  sync_resync_xor_frame_receiver_core DUT (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] fill;
    logic [7:0] code;
    logic       ok;
    logic       complete;
    logic       ignored;
  } status_t;

  // predicted receiver state
  logic [7:0] frame_mem [BufBytes];
  int unsigned held;
  logic [7:0] xsum;
  bit done;
  logic [7:0] sync_byte;
  logic [7:0] target_sum;

  status_t status_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [7:0] store_xor(input int unsigned n);
    logic [7:0] acc;
    acc = 0;
    for (int i = 0; i < n; i++) acc ^= frame_mem[i];
    return acc;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    int unsigned drop;
    int unsigned want;
    frame_mem[held] = b;
    held++;
    xsum ^= b;
    do begin
      drop = 0;
      if (frame_mem[0] != sync_byte) begin
        drop = 1;
      end else if (held >= 4) begin
        want = 4 + 2 * frame_mem[2];
        if (want > BufBytes) drop = 1;
        else if (held >= want) begin
          if (xsum != target_sum) drop = 1;
          else begin
            for (int i = held; i < BufBytes; i++) frame_mem[i] = 0;
            done = 1;
          end
        end
      end
      if (drop != 0) begin
        while (drop < held && frame_mem[drop] != sync_byte) drop++;
        held -= drop;
        for (int i = 0; i < held; i++) frame_mem[i] = frame_mem[i + drop];
        xsum = store_xor(held);
      end
    end while (drop != 0 && held != 0);
  endfunction

  function automatic status_t predict_status(input op_t op, input logic [7:0] b,
                                             input logic [6:0] idx);
    status_t s;
    int unsigned pos;
    s = '0;
    if (op == OP_RECV) begin
      if (done) s.ignored = 1;
      else if (held < BufBytes) absorb_byte(b);
    end else if (op == OP_RESTART) begin
      held = 0;
      xsum = 0;
      done = 0;
    end
    s.complete = done;
    s.code = done ? frame_mem[3] : 8'd0;
    s.ok = done && s.code == 0;
    pos = 4 + idx;
    if (op == OP_READ && s.ok && pos < held && pos < BufBytes) s.rd = frame_mem[pos];
    s.fill = held[7:0];
    return s;
  endfunction

  // one transaction on the input channel; tvalid drops only while idling
  task automatic send_item(input op_t op, input logic [7:0] b, input logic [6:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, idx, b, op};
    do @(posedge clk); while (!in_tready);
    status_q.push_back(predict_status(op, b, idx));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_RECV, b, 7'($urandom));
  endtask

  // send a well-formed frame with n words and reply code
  task automatic send_frame(input int n, input logic [7:0] code);
    logic [7:0] pay [$];
    logic [7:0] acc;
    pay = {};
    acc = sync_byte ^ n[7:0] ^ code;
    for (int i = 0; i < 2 * n; i++) begin
      pay.push_back(8'($urandom));
      acc ^= pay[i];
    end
    send_byte(sync_byte);
    send_byte(acc ^ target_sum);
    send_byte(n[7:0]);
    send_byte(code);
    foreach (pay[i]) send_byte(pay[i]);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SYNC) sync_byte = v;
    else target_sum = v;
  endtask

  task automatic read_all(input int n);
    for (int i = 0; i < n; i++) send_item(OP_READ, 8'($urandom), i[6:0]);
    send_item(OP_READ, 8'($urandom), 7'd127);
  endtask

  task automatic test_directed;
    send_item(OP_READ, 8'hff, 7'd0);           // read when not complete
    send_item(OP_NONE, 8'hff, 7'h7f);          // unused operation
    send_byte(8'h33);                          // bad sync dropped
    send_frame(0, 8'h00);
    send_byte(8'hff);                          // ignored while complete
    read_all(1);
    send_item(OP_RESTART, 8'h00, 7'd0);
    send_frame(62, 8'h00);                     // largest frame that fits
    send_item(OP_READ, 8'h00, 7'd123);
    send_item(OP_READ, 8'h00, 7'd0);
    send_item(OP_RESTART, 8'h00, 7'd0);
    send_frame(1, 8'hff);                      // nonzero code: reads give zero
    send_item(OP_READ, 8'h00, 7'd1);
    send_item(OP_RESTART, 8'h00, 7'd0);
  endtask

  task automatic test_resync;
    // oversize count, then a bad checksum, then a good frame behind them
    send_byte(sync_byte);
    send_byte(8'h00);
    send_byte(8'd63);
    send_byte(8'h00);
    send_byte(sync_byte);
    send_byte(8'h5a);
    send_byte(8'd0);
    send_byte(8'h01);
    send_frame(2, 8'h00);
    read_all(4);
    send_item(OP_RESTART, 8'h00, 7'd0);
  endtask

  task automatic test_random(input int n);
    int k;
    int n_words;
    k = 0;
    while (k < n) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          n_words = $urandom_range(99) < 90 ? $urandom_range(6) : $urandom_range(62);
          send_frame(n_words, $urandom_range(1) ? 8'h00 : 8'($urandom));
          k += 4 + 2 * n_words;
        end
        4: begin
          send_byte($urandom_range(1) ? sync_byte : 8'($urandom));
          k++;
        end
        5: begin
          send_item(OP_RESTART, 8'($urandom), 7'($urandom));
          k++;
        end
        6: begin
          send_item(OP_NONE, 8'($urandom), 7'($urandom));
          k++;
        end
        default: begin
          send_item(OP_READ, 8'($urandom),
                    7'($urandom_range(1) ? $urandom_range(20) : $urandom));
          k++;
        end
      endcase
    end
    send_item(OP_RESTART, 8'h00, 7'd0);
  endtask

  // receiver idling and the long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    status_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[18+8:0];
      if (status_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        want = status_q.pop_front();
        if (got.ignored !== want.ignored) report_mismatch("byte_ignored", got.ignored, want.ignored);
        if (got.complete !== want.complete)
          report_mismatch("reply_complete", got.complete, want.complete);
        if (got.ok !== want.ok) report_mismatch("reply_ok", got.ok, want.ok);
        if (got.code !== want.code) report_mismatch("reply_code", got.code, want.code);
        if (got.fill !== want.fill) report_mismatch("fill_count", got.fill, want.fill);
        if (got.rd !== want.rd) report_mismatch("read_byte", got.rd, want.rd);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 60000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    held = 0;
    xsum = 0;
    done = 0;
    sync_byte = 8'h00;
    target_sum = 8'h5a;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 86;
    test_directed();
    test_resync();
    drain();
    write_reg(CFG_SYNC, 8'hff);
    write_reg(CFG_TARGET, 8'h00);
    test_directed();
    test_resync();
    test_random(300);
    drain();

    send_idle_pct = 86;
    recv_idle_pct = 18;
    write_reg(CFG_SYNC, 8'ha5);
    write_reg(CFG_TARGET, 8'hff);
    test_random(300);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_SYNC, 8'h00);
    write_reg(CFG_TARGET, 8'h5a);
    hold_cycles = 3000;                        // receiver stalls, input backs up
    test_random(500);
    drain();

    if (errors == 0 && status_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/srxf_pkg.sv
rtl/sync_resync_xor_frame_receiver_core.sv
rtl/srxf_checker.sv
tb/tb_sync_resync_xor_frame_receiver_core.sv
